// File: rtl/core/tft_pkg.sv
package tft_pkg;

   // shared arithmetic widths
   localparam int ACC_W  = 128;
   localparam int B_W    = 64;
   localparam int STEP_W = 4;
   localparam int QUOT_W = 32;

   localparam int SUBPIXEL_BITS_DEF = 4;

   // stream payload widths
   localparam int REQ_W = 160;
   localparam int RSP_W = 96;

   // byte steps of the multiply-accumulate unit per operand width
   localparam logic [STEP_W-1:0] STEPS_ONE  = 4'd1;
   localparam logic [STEP_W-1:0] STEPS_W16  = 4'd2;
   localparam logic [STEP_W-1:0] STEPS_EDGE = 4'd3;
   localparam logic [STEP_W-1:0] STEPS_W32  = 4'd4;
   localparam logic [STEP_W-1:0] STEPS_W64  = 4'd8;

   localparam logic OPC_LOAD = 1'b0;
   localparam logic OPC_TEST = 1'b1;

   localparam logic [1:0] STATUS_NOCOVER = 2'd0;
   localparam logic [1:0] STATUS_CULLED  = 2'd1;
   localparam logic [1:0] STATUS_DEPTH   = 2'd2;
   localparam logic [1:0] STATUS_WRITE   = 2'd3;

   localparam logic [1:0] CSR_VIEWPORT_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_VIEWPORT_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TEXTURE_WIDTH   = 2'd2;
   localparam logic [1:0] CSR_TEXTURE_HEIGHT  = 2'd3;

   typedef struct packed {
      logic              start;
      logic              clear;
      logic [STEP_W-1:0] steps;
   } mac_cmd_type;

   typedef struct packed {
      logic start;
      logic half;
   } div_cmd_type;

endpackage

// File: rtl/core/tft_mac.sv
module tft_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  tft_pkg::mac_cmd_type      cmd,
   input  logic [tft_pkg::ACC_W-1:0] a,
   input  logic [tft_pkg::B_W-1:0]   b,
   output logic                      busy,
   output logic [tft_pkg::ACC_W-1:0] acc
);
   import tft_pkg::*;

   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  a_ff;
   logic [B_W-1:0]    b_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [ACC_W-1:0]  prod;

   // one byte of the multiplier per cycle
   assign prod = a_ff * ACC_W'(b_ff[7:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start) begin
         cnt_ff <= cmd.steps;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.start) begin
         a_ff <= a;
         b_ff <= b;
         if (cmd.clear) begin
            acc_ff <= '0;
         end
      end else if (cnt_ff != '0) begin
         acc_ff <= acc_ff + prod;
         a_ff   <= a_ff << 8;
         b_ff   <= b_ff >> 8;
      end
   end

   assign busy = (cnt_ff != '0);
   assign acc  = acc_ff;

endmodule

// File: rtl/core/tft_div.sv
module tft_div #(
   parameter int D_W = 105
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tft_pkg::div_cmd_type              cmd,
   input  logic [D_W+tft_pkg::QUOT_W-1:0]    num,
   input  logic [D_W-1:0]                    den,
   output logic                              busy,
   output logic [tft_pkg::QUOT_W-1:0]        quot
);
   import tft_pkg::*;

   localparam int HALF_W = QUOT_W / 2;
   localparam int CNT_W  = $clog2(QUOT_W + 1);

   logic [D_W-1:0]    rem_ff;
   logic [D_W-1:0]    den_ff;
   logic [QUOT_W-1:0] q_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              zero_ff;
   logic [D_W:0]      trial;
   logic [D_W:0]      diff;
   logic              ge;

   // restoring step; the quotient is known to fit, so the remainder starts below the divisor
   assign trial = {rem_ff, q_ff[QUOT_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start) begin
         cnt_ff <= cmd.half ? CNT_W'(HALF_W) : CNT_W'(QUOT_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.start) begin
         den_ff  <= den;
         zero_ff <= (den == '0);
         if (cmd.half) begin
            rem_ff <= num[D_W+HALF_W-1:HALF_W];
            q_ff   <= {num[HALF_W-1:0], {HALF_W{1'b0}}};
         end else begin
            rem_ff <= num[D_W+QUOT_W-1:QUOT_W];
            q_ff   <= num[QUOT_W-1:0];
         end
      end else if (cnt_ff != '0) begin
         rem_ff <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
         q_ff   <= {q_ff[QUOT_W-2:0], ge};
      end
   end

   assign busy = (cnt_ff != '0);
   assign quot = zero_ff ? '0 : q_ff;

endmodule

// File: rtl/core/triangle_fragment_tester_core.sv
// channel  | direction | transfer when          | payload
// req      | in        | req_tvalid & tready    | tuser opcode, tdata vertex or pixel fields
// rsp      | out       | rsp_tvalid & tready    | tuser status, tdata pixel, depth, texel
// csr      | in        | csr_valid & csr_ready  | csr_index, csr_data (always ready)
//
// a vertex load gives no result
// a pixel stops at the viewport test if outside, after the area if culled, after the edges
// if not covered, after the depth divide on a depth fail, else after the texel address; the
// shared byte-serial multiply-accumulate unit and one-bit-a-cycle divider do its steps
// the block takes no new transfer while a pixel is in work; a result waiting on rsp
// does not block the next transfer, only the emit of the following result
// reset is synchronous, active high, and restores the register and vertex defaults
module triangle_fragment_tester_core #(
   parameter int SUBPIXEL_BITS = tft_pkg::SUBPIXEL_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // opcode
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // vertex_slot, vertex_x, vertex_y, vertex_w, vertex_u, vertex_v,
   // pixel_x, pixel_y, stored_depth
   input  logic [tft_pkg::REQ_W-1:0] req_tdata,
   input  logic                      req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_x, out_y, new_depth, texel_x, texel_y, texel_address
   output logic [tft_pkg::RSP_W-1:0] rsp_tdata,
   // status
   output logic [1:0]                rsp_tuser,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [12:0]               csr_data
);
   import tft_pkg::*;

   // sample coordinate, signed differences, edge values, weights and weight sum
   localparam int SAMP_W = 13 + SUBPIXEL_BITS;
   localparam int DIFF_W = ((SAMP_W > 17) ? SAMP_W : 17) + 2;
   localparam int E_W    = DIFF_W + 20;
   localparam int T_W    = E_W + 64;
   localparam int D_W    = T_W + 2;
   localparam int NUM_W  = D_W + QUOT_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_VIEW, ST_MAC_GO, ST_MAC_WAIT, ST_COVER, ST_DIV_GO, ST_DIV_WAIT, ST_EMIT
   } state_type;

   // micro-operations of the shared multiply-accumulate unit, in program order
   typedef enum logic [4:0] {
      OP_AREA_A, OP_AREA_B, OP_E0_A, OP_E0_B, OP_E1_A, OP_E1_B, OP_E2_A, OP_E2_B,
      OP_NUM0, OP_NUM1, OP_NUM2, OP_Q0, OP_Q1, OP_Q2, OP_T0, OP_T1, OP_T2,
      OP_DEN0, OP_DEN1, OP_DEN2, OP_NU0, OP_NU1, OP_NU2, OP_NV0, OP_NV1, OP_NV2,
      OP_TX, OP_TY, OP_AD0, OP_AD1
   } op_type;

   function automatic logic signed [DIFF_W-1:0] dif(input logic signed [DIFF_W-1:0] p,
                                                    input logic signed [DIFF_W-1:0] q);
      return p - q;
   endfunction

   function automatic logic top_left(input logic signed [17:0] dx, input logic signed [17:0] dy);
      return (dx != 0) ? (dx > 0) : (dy > 0);
   endfunction

   function automatic logic covered(input logic signed [E_W-1:0] e, input logic tl);
      return (e == 0) ? tl : (e > 0);
   endfunction

   function automatic logic [10:0] clamp_size(input logic [10:0] s);
      logic [10:0] r;
      if (s == 11'd0) begin
         r = 11'd1;
      end else if (s > 11'd1024) begin
         r = 11'd1024;
      end else begin
         r = s;
      end
      return r;
   endfunction

   // configuration
   logic [12:0] vpw_ff, vph_ff;
   logic [10:0] txw_ff, txh_ff;

   // vertex store
   logic [15:0] vx_ff [3];
   logic [15:0] vy_ff [3];
   logic [31:0] vw_ff [3];
   logic [15:0] vu_ff [3];
   logic [15:0] vv_ff [3];

   // sequencer
   state_type   state_ff;
   op_type      op_ff;
   op_type      op_step;
   logic [11:0] px_ff, py_ff;
   logic [31:0] sd_ff;
   logic [E_W-1:0] area_ff;
   logic [E_W-1:0] e_ff [3];
   logic [63:0]    q_ff [3];
   logic [T_W-1:0] t_ff [3];
   logic [D_W-1:0] den_ff;
   logic [31:0] depth_ff;
   logic [15:0] uq_ff, vq_ff;
   logic [9:0]  tx_ff, ty_ff;
   logic [19:0] addr_ff;
   logic [1:0]  status_ff;

   logic             rsp_tvalid_ff;
   logic [RSP_W-1:0] rsp_tdata_ff;
   logic [1:0]       rsp_tuser_ff;

   logic req_xfer;
   logic [1:0] slot;

   logic signed [16:0] xs [3];
   logic signed [16:0] ys [3];
   logic [SAMP_W-1:0]  sx, sy;
   logic signed [DIFF_W-1:0] sxs, sys;
   logic signed [17:0] dx01, dx12, dx20, dy01, dy12, dy20;
   logic [10:0] tw_c, th_c, tw_m1, th_m1;

   mac_cmd_type      mac_cmd;
   logic [ACC_W-1:0] mac_a;
   logic [B_W-1:0]   mac_b;
   logic             mac_busy;
   logic [ACC_W-1:0] acc;
   logic signed [E_W-1:0] acc_e;

   div_cmd_type       div_cmd;
   logic [NUM_W-1:0]  div_num;
   logic [D_W-1:0]    div_den;
   logic              div_busy;
   logic [QUOT_W-1:0] quot;

   logic                     edge_op;
   logic                     edge_neg;
   logic signed [DIFF_W-1:0] edge_a;
   logic signed [17:0]       edge_b;
   logic [ACC_W-1:0]         edge_a_ext;
   logic [17:0]              edge_b_mag;
   logic                     cover_ok;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign slot       = req_tdata[1:0];
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   assign op_step = op_type'(op_ff + 5'd1);

   // coordinates doubled so the pixel centre lands on an integer
   for (genvar i = 0; i < 3; i++) begin : g_coord
      assign xs[i] = $signed({vx_ff[i], 1'b0});
      assign ys[i] = $signed({vy_ff[i], 1'b0});
   end

   assign sx  = {px_ff, {(SUBPIXEL_BITS+1){1'b0}}} | SAMP_W'(2**SUBPIXEL_BITS);
   assign sy  = {py_ff, {(SUBPIXEL_BITS+1){1'b0}}} | SAMP_W'(2**SUBPIXEL_BITS);
   assign sxs = $signed(DIFF_W'(sx));
   assign sys = $signed(DIFF_W'(sy));

   assign dx01 = 18'(xs[1]) - 18'(xs[0]);
   assign dx12 = 18'(xs[2]) - 18'(xs[1]);
   assign dx20 = 18'(xs[0]) - 18'(xs[2]);
   assign dy01 = 18'(ys[1]) - 18'(ys[0]);
   assign dy12 = 18'(ys[2]) - 18'(ys[1]);
   assign dy20 = 18'(ys[0]) - 18'(ys[2]);

   assign tw_c  = clamp_size(txw_ff);
   assign th_c  = clamp_size(txh_ff);
   assign tw_m1 = tw_c - 11'd1;
   assign th_m1 = th_c - 11'd1;

   assign acc_e = $signed(acc[E_W-1:0]);

   assign cover_ok = covered($signed(e_ff[0]), top_left(dx12, dy12)) &&
                     covered($signed(e_ff[1]), top_left(dx20, dy20)) &&
                     covered($signed(e_ff[2]), top_left(dx01, dy01));

   // operand selection for the shared unit
   // edge products: b is taken as a magnitude, its sign moved onto a
   assign edge_a_ext = ACC_W'(edge_a);
   assign edge_b_mag = edge_b[17] ? 18'(-edge_b) : edge_b;

   always_comb begin
      edge_op       = 1'b0;
      edge_neg      = 1'b0;
      edge_a        = '0;
      edge_b        = '0;
      mac_a         = '0;
      mac_b         = '0;
      mac_cmd.start = (state_ff == ST_MAC_GO);
      mac_cmd.clear = 1'b0;
      mac_cmd.steps = STEPS_ONE;
      unique case (op_ff)
         OP_AREA_A: begin
            edge_op = 1'b1; mac_cmd.clear = 1'b1;
            edge_a = dif(DIFF_W'(xs[2]), DIFF_W'(xs[0])); edge_b = dy01;
         end
         OP_AREA_B: begin
            edge_op = 1'b1; edge_neg = 1'b1;
            edge_a = dif(DIFF_W'(ys[2]), DIFF_W'(ys[0])); edge_b = dx01;
         end
         OP_E0_A: begin
            edge_op = 1'b1; mac_cmd.clear = 1'b1;
            edge_a = dif(sxs, DIFF_W'(xs[1])); edge_b = dy12;
         end
         OP_E0_B: begin
            edge_op = 1'b1; edge_neg = 1'b1;
            edge_a = dif(sys, DIFF_W'(ys[1])); edge_b = dx12;
         end
         OP_E1_A: begin
            edge_op = 1'b1; mac_cmd.clear = 1'b1;
            edge_a = dif(sxs, DIFF_W'(xs[2])); edge_b = dy20;
         end
         OP_E1_B: begin
            edge_op = 1'b1; edge_neg = 1'b1;
            edge_a = dif(sys, DIFF_W'(ys[2])); edge_b = dx20;
         end
         OP_E2_A: begin
            edge_op = 1'b1; mac_cmd.clear = 1'b1;
            edge_a = dif(sxs, DIFF_W'(xs[0])); edge_b = dy01;
         end
         OP_E2_B: begin
            edge_op = 1'b1; edge_neg = 1'b1;
            edge_a = dif(sys, DIFF_W'(ys[0])); edge_b = dx01;
         end
         OP_NUM0: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W32;
            mac_a = ACC_W'(e_ff[0]); mac_b = B_W'(vw_ff[0]);
         end
         OP_NUM1: begin
            mac_cmd.steps = STEPS_W32;
            mac_a = ACC_W'(e_ff[1]); mac_b = B_W'(vw_ff[1]);
         end
         OP_NUM2: begin
            mac_cmd.steps = STEPS_W32;
            mac_a = ACC_W'(e_ff[2]); mac_b = B_W'(vw_ff[2]);
         end
         OP_Q0: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W32;
            mac_a = ACC_W'(vw_ff[1]); mac_b = B_W'(vw_ff[2]);
         end
         OP_Q1: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W32;
            mac_a = ACC_W'(vw_ff[0]); mac_b = B_W'(vw_ff[2]);
         end
         OP_Q2: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W32;
            mac_a = ACC_W'(vw_ff[0]); mac_b = B_W'(vw_ff[1]);
         end
         OP_T0: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W64;
            mac_a = ACC_W'(e_ff[0]); mac_b = q_ff[0];
         end
         OP_T1: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W64;
            mac_a = ACC_W'(e_ff[1]); mac_b = q_ff[1];
         end
         OP_T2: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W64;
            mac_a = ACC_W'(e_ff[2]); mac_b = q_ff[2];
         end
         OP_DEN0: begin
            mac_cmd.clear = 1'b1;
            mac_a = ACC_W'(t_ff[0]); mac_b = B_W'(1);
         end
         OP_DEN1: begin
            mac_a = ACC_W'(t_ff[1]); mac_b = B_W'(1);
         end
         OP_DEN2: begin
            mac_a = ACC_W'(t_ff[2]); mac_b = B_W'(1);
         end
         OP_NU0: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W16;
            mac_a = ACC_W'(t_ff[0]); mac_b = B_W'(vu_ff[0]);
         end
         OP_NU1: begin
            mac_cmd.steps = STEPS_W16;
            mac_a = ACC_W'(t_ff[1]); mac_b = B_W'(vu_ff[1]);
         end
         OP_NU2: begin
            mac_cmd.steps = STEPS_W16;
            mac_a = ACC_W'(t_ff[2]); mac_b = B_W'(vu_ff[2]);
         end
         OP_NV0: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W16;
            mac_a = ACC_W'(t_ff[0]); mac_b = B_W'(vv_ff[0]);
         end
         OP_NV1: begin
            mac_cmd.steps = STEPS_W16;
            mac_a = ACC_W'(t_ff[1]); mac_b = B_W'(vv_ff[1]);
         end
         OP_NV2: begin
            mac_cmd.steps = STEPS_W16;
            mac_a = ACC_W'(t_ff[2]); mac_b = B_W'(vv_ff[2]);
         end
         OP_TX: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W16;
            mac_a = ACC_W'(uq_ff); mac_b = B_W'(tw_c);
         end
         OP_TY: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W16;
            mac_a = ACC_W'(vq_ff); mac_b = B_W'(th_c);
         end
         OP_AD0: begin
            mac_cmd.clear = 1'b1; mac_cmd.steps = STEPS_W16;
            mac_a = ACC_W'(ty_ff); mac_b = B_W'(tw_c);
         end
         OP_AD1: begin
            mac_a = ACC_W'(tx_ff); mac_b = B_W'(1);
         end
         default: begin
            mac_a = '0;
         end
      endcase
      if (edge_op) begin
         mac_cmd.steps = STEPS_EDGE;
         mac_a = (edge_b[17] ^ edge_neg) ? -edge_a_ext : edge_a_ext;
         mac_b = B_W'(edge_b_mag);
      end
   end

   // depth divides by the area in full width, texture coordinates by the weight sum
   assign div_cmd.start = (state_ff == ST_DIV_GO);
   assign div_cmd.half  = (op_ff != OP_NUM2);
   assign div_num       = {{(NUM_W-ACC_W){1'b0}}, acc};
   assign div_den       = (op_ff == OP_NUM2) ? D_W'(area_ff) : den_ff;

   tft_mac u_mac (
      .clock (clock),
      .reset (reset),
      .cmd   (mac_cmd),
      .a     (mac_a),
      .b     (mac_b),
      .busy  (mac_busy),
      .acc   (acc)
   );

   tft_div #(
      .D_W (D_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (quot)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vpw_ff <= 13'd640;
         vph_ff <= 13'd480;
         txw_ff <= 11'd256;
         txh_ff <= 11'd256;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VIEWPORT_WIDTH:  vpw_ff <= csr_data;
            CSR_VIEWPORT_HEIGHT: vph_ff <= csr_data;
            CSR_TEXTURE_WIDTH:   txw_ff <= csr_data[10:0];
            CSR_TEXTURE_HEIGHT:  txh_ff <= csr_data[10:0];
            default:             vpw_ff <= vpw_ff;
         endcase
      end
   end

   // vertex store, written straight from a load transfer; slot three is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= '0;
            vy_ff[i] <= '0;
            vw_ff[i] <= 32'h0001_0000;
            vu_ff[i] <= '0;
            vv_ff[i] <= '0;
         end
      end else if (req_xfer && (req_tuser == OPC_LOAD) && (slot != 2'd3)) begin
         vx_ff[slot] <= req_tdata[17:2];
         vy_ff[slot] <= req_tdata[33:18];
         vw_ff[slot] <= req_tdata[65:34];
         vu_ff[slot] <= req_tdata[81:66];
         vv_ff[slot] <= req_tdata[97:82];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_AREA_A;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // the emit state refills the result register itself
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_EMIT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer && (req_tuser == OPC_TEST)) begin
                  px_ff    <= req_tdata[109:98];
                  py_ff    <= req_tdata[121:110];
                  sd_ff    <= req_tdata[153:122];
                  state_ff <= ST_VIEW;
               end
            end
            ST_VIEW: begin
               // viewport test comes before the backface test
               if ((13'(px_ff) >= vpw_ff) || (13'(py_ff) >= vph_ff)) begin
                  status_ff <= STATUS_NOCOVER;
                  state_ff  <= ST_EMIT;
               end else begin
                  op_ff    <= OP_AREA_A;
                  state_ff <= ST_MAC_GO;
               end
            end
            ST_MAC_GO: begin
               state_ff <= ST_MAC_WAIT;
            end
            ST_MAC_WAIT: begin
               if (!mac_busy) begin
                  // capture of the finished product
                  unique case (op_ff)
                     OP_AREA_B: area_ff <= acc[E_W-1:0];
                     OP_E0_B: e_ff[0] <= acc[E_W-1:0];
                     OP_E1_B: e_ff[1] <= acc[E_W-1:0];
                     OP_E2_B: e_ff[2] <= acc[E_W-1:0];
                     OP_Q0: q_ff[0] <= acc[63:0];
                     OP_Q1: q_ff[1] <= acc[63:0];
                     OP_Q2: q_ff[2] <= acc[63:0];
                     OP_T0: t_ff[0] <= acc[T_W-1:0];
                     OP_T1: t_ff[1] <= acc[T_W-1:0];
                     OP_T2: t_ff[2] <= acc[T_W-1:0];
                     OP_DEN2: den_ff <= acc[D_W-1:0];
                     OP_TX: tx_ff <= (acc[26:16] > tw_m1) ? tw_m1[9:0] : acc[25:16];
                     OP_TY: ty_ff <= (acc[26:16] > th_m1) ? th_m1[9:0] : acc[25:16];
                     OP_AD1: addr_ff <= acc[19:0];
                     default: begin
                        area_ff <= area_ff;
                     end
                  endcase
                  // where the program goes next
                  priority if ((op_ff == OP_AREA_B) && (acc_e <= 0)) begin
                     // zero area counts as culled
                     status_ff <= STATUS_CULLED;
                     state_ff  <= ST_EMIT;
                  end else if (op_ff == OP_AD1) begin
                     status_ff <= STATUS_WRITE;
                     state_ff  <= ST_EMIT;
                  end else if (op_ff == OP_E2_B) begin
                     state_ff <= ST_COVER;
                  end else if ((op_ff == OP_NUM2) || (op_ff == OP_NU2) ||
                               (op_ff == OP_NV2)) begin
                     state_ff <= ST_DIV_GO;
                  end else begin
                     op_ff    <= op_step;
                     state_ff <= ST_MAC_GO;
                  end
               end
            end
            ST_COVER: begin
               if (cover_ok) begin
                  op_ff    <= OP_NUM0;
                  state_ff <= ST_MAC_GO;
               end else begin
                  status_ff <= STATUS_NOCOVER;
                  state_ff  <= ST_EMIT;
               end
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (!div_busy) begin
                  priority case (op_ff)
                     OP_NUM2: begin
                        depth_ff <= quot;
                        op_ff    <= OP_Q0;
                        if (quot >= sd_ff) begin
                           status_ff <= STATUS_DEPTH;
                           state_ff  <= ST_EMIT;
                        end else begin
                           state_ff <= ST_MAC_GO;
                        end
                     end
                     OP_NU2: begin
                        uq_ff    <= quot[15:0];
                        op_ff    <= OP_NV0;
                        state_ff <= ST_MAC_GO;
                     end
                     default: begin
                        vq_ff    <= quot[15:0];
                        op_ff    <= OP_TX;
                        state_ff <= ST_MAC_GO;
                     end
                  endcase
               end
            end
            ST_EMIT: begin
               // results other than a write carry zero depth and texel fields
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tuser_ff  <= status_ff;
                  if (status_ff == STATUS_WRITE) begin
                     rsp_tdata_ff <= {addr_ff, ty_ff, tx_ff, depth_ff, py_ff, px_ff};
                  end else begin
                     rsp_tdata_ff <= {72'd0, py_ff, px_ff};
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
